[rtl/core/drt_pkg.sv]
// Shared types and constants of the dispatch and retry tracker.
// Used by drt_ctrl, drt_datapath and dispatch_retry_tracker; depends on nothing.
package drt_pkg;

    localparam int PEND_DEPTH = 64;
    localparam int PEND_AW    = 6;
    localparam int PCNT_W     = 7;
    localparam int FLT_DEPTH  = 32;
    localparam int FLT_AW     = 5;
    localparam int FCNT_W     = 6;

    // Operation codes
    localparam logic [2:0] F_PUSH  = 3'd0;
    localparam logic [2:0] F_DISP  = 3'd1;
    localparam logic [2:0] F_ACK   = 3'd2;
    localparam logic [2:0] F_TMO   = 3'd3;
    localparam logic [2:0] F_RETRY = 3'd4;

    // Result status codes
    localparam logic [2:0] S_OK        = 3'd0;
    localparam logic [2:0] S_PEMPTY    = 3'd1;
    localparam logic [2:0] S_PFULL     = 3'd2;
    localparam logic [2:0] S_FFULL     = 3'd3;
    localparam logic [2:0] S_NOTFOUND  = 3'd4;
    localparam logic [2:0] S_SWEEP_END = 3'd5;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic p1_start;
        logic p1_step;
        logic p2_start;
        logic p2_step;
        logic fin;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0]        func;
        logic              at_end;
        logic              emit_need;
        logic              out_free;
        logic [PCNT_W-1:0] pfill;
        logic [FCNT_W-1:0] ffill;
    } dp_stat_t;

endpackage

[rtl/core/drt_ctrl.sv]
// Sequencer of the dispatch and retry tracker: decodes each item and steps
// the datapath through single operations or the two passes of a sweep. Uses drt_pkg.
module drt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  drt_pkg::dp_stat_t stat,
    output drt_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_P1_RD = 3'd3;
    localparam logic [2:0] ST_P1_EV = 3'd4;
    localparam logic [2:0] ST_P2_RD = 3'd5;
    localparam logic [2:0] ST_P2_EV = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_sweep;

    assign is_sweep = (stat.func == drt_pkg::F_ACK) || (stat.func == drt_pkg::F_TMO)
                      || (stat.func == drt_pkg::F_RETRY);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (is_sweep)
                begin
                    cmd.p1_start = 1'b1;
                    state_next   = ST_P1_RD;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_P1_RD:
            begin
                if (stat.at_end)
                begin
                    cmd.p2_start = 1'b1;
                    state_next   = ST_P2_RD;
                end
                else
                begin
                    state_next = ST_P1_EV;
                end
            end
            ST_P1_EV:
            begin
                cmd.p1_step = 1'b1;
                state_next  = ST_P1_RD;
            end
            ST_P2_RD:
            begin
                state_next = stat.at_end ? ST_FIN : ST_P2_EV;
            end
            ST_P2_EV:
            begin
                // hold while a reported entry cannot reach the output register
                if (!stat.emit_need || stat.out_free)
                begin
                    cmd.p2_step = 1'b1;
                    state_next  = ST_P2_RD;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/drt_datapath.sv]
// Datapath of the dispatch and retry tracker: pending FIFO memory, in-flight
// list memory, counters, sweep bookkeeping and the output register. Uses drt_pkg.
module drt_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [135:0]      s_tdata,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_data,
    input  drt_pkg::dp_cmd_t  cmd,
    output drt_pkg::dp_stat_t stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [87:0]       m_tdata,
    output logic              m_tlast
);

    localparam int PAW = drt_pkg::PEND_AW;
    localparam int FAW = drt_pkg::FLT_AW;
    localparam int PCW = drt_pkg::PCNT_W;
    localparam int FCW = drt_pkg::FCNT_W;

    // latched item
    logic [2:0]  func_reg;
    logic [63:0] id_reg;
    logic [31:0] now_reg;
    logic [31:0] cut_reg;
    logic [7:0]  limit_reg;

    // stores
    logic [63:0] pend_id_mem  [drt_pkg::PEND_DEPTH];
    logic [7:0]  pend_att_mem [drt_pkg::PEND_DEPTH];
    logic [63:0] flt_id_mem   [drt_pkg::FLT_DEPTH];
    logic [7:0]  flt_att_mem  [drt_pkg::FLT_DEPTH];
    logic [31:0] flt_time_mem [drt_pkg::FLT_DEPTH];
    logic [63:0] pend_id_rd_reg;
    logic [7:0]  pend_att_rd_reg;
    logic [63:0] flt_id_rd_reg;
    logic [7:0]  flt_att_rd_reg;
    logic [31:0] flt_time_rd_reg;

    logic [PAW-1:0] head_reg,   head_next;
    logic [PCW-1:0] pfill_reg,  pfill_next;
    logic [FCW-1:0] ffill_reg,  ffill_next;
    logic [FCW-1:0] r_reg,      r_next;
    logic [FCW-1:0] w_reg,      w_next;
    logic [FCW-1:0] cnt_reg,    cnt_next;
    logic [FCW-1:0] moved_reg,  moved_next;
    logic [FCW-1:0] taken_reg,  taken_next;
    logic           blocked_reg, blocked_next;
    logic [PCW-1:0] pfinal_reg, pfinal_next;
    logic [FCW-1:0] ffinal_reg, ffinal_next;

    logic           ovalid_reg, ovalid_next;
    logic [2:0]     ostat_reg,  ostat_next;
    logic [63:0]    oid_reg,    oid_next;
    logic [7:0]     oatt_reg,   oatt_next;
    logic [PCW-1:0] opc_reg,    opc_next;
    logic [FCW-1:0] ofc_reg,    ofc_next;
    logic           olast_reg,  olast_next;

    // memory write ports
    logic           pend_we;
    logic [PAW-1:0] pend_waddr;
    logic [63:0]    pend_wid;
    logic [7:0]     pend_watt;
    logic           flt_we;
    logic [FAW-1:0] flt_waddr;
    logic [63:0]    flt_wid;
    logic [7:0]     flt_watt;
    logic [31:0]    flt_wtime;

    logic [PAW-1:0] tail;
    logic           elig;
    logic           take;
    logic           is_tmo;
    logic [PCW-1:0] space;
    logic [FCW-1:0] moved_calc;
    logic [7:0]     att_inc;

    assign tail    = head_reg + pfill_reg[PAW-1:0];
    assign is_tmo  = (func_reg == drt_pkg::F_TMO);
    assign att_inc = (pend_att_rd_reg == 8'hFF) ? 8'hFF : pend_att_rd_reg + 8'd1;
    assign space   = PCW'(drt_pkg::PEND_DEPTH) - pfill_reg;
    assign moved_calc = (is_tmo && ({1'b0, cnt_reg} > space)) ? space[FCW-1:0] : cnt_reg;

    always_comb
    begin
        case (func_reg)
            drt_pkg::F_ACK:   elig = (flt_id_rd_reg == id_reg);
            drt_pkg::F_TMO:   elig = (flt_time_rd_reg < cut_reg);
            drt_pkg::F_RETRY: elig = (flt_att_rd_reg >= limit_reg);
            default:          elig = 1'b0;
        endcase
    end

    assign take = elig && (taken_reg < moved_reg);

    assign stat.func      = func_reg;
    assign stat.at_end    = (r_reg == ffill_reg);
    assign stat.emit_need = take && (func_reg != drt_pkg::F_ACK);
    assign stat.out_free  = !ovalid_reg || m_tready;
    assign stat.pfill     = pfill_reg;
    assign stat.ffill     = ffill_reg;

    always_comb
    begin
        head_next    = head_reg;
        pfill_next   = pfill_reg;
        ffill_next   = ffill_reg;
        r_next       = r_reg;
        w_next       = w_reg;
        cnt_next     = cnt_reg;
        moved_next   = moved_reg;
        taken_next   = taken_reg;
        blocked_next = blocked_reg;
        pfinal_next  = pfinal_reg;
        ffinal_next  = ffinal_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        ostat_next   = ostat_reg;
        oid_next     = oid_reg;
        oatt_next    = oatt_reg;
        opc_next     = opc_reg;
        ofc_next     = ofc_reg;
        olast_next   = olast_reg;
        pend_we      = 1'b0;
        pend_waddr   = tail;
        pend_wid     = id_reg;
        pend_watt    = 8'd0;
        flt_we       = 1'b0;
        flt_waddr    = w_reg[FAW-1:0];
        flt_wid      = flt_id_rd_reg;
        flt_watt     = flt_att_rd_reg;
        flt_wtime    = flt_time_rd_reg;

        if (cmd.exec)
        begin
            ostat_next = drt_pkg::S_OK;
            oid_next   = 64'd0;
            oatt_next  = 8'd0;
            case (func_reg)
                drt_pkg::F_PUSH:
                begin
                    if (pfill_reg == PCW'(drt_pkg::PEND_DEPTH))
                        ostat_next = drt_pkg::S_PFULL;
                    else
                    begin
                        pend_we    = 1'b1;
                        pfill_next = pfill_reg + PCW'(1);
                    end
                end
                drt_pkg::F_DISP:
                begin
                    if (pfill_reg == '0)
                        ostat_next = drt_pkg::S_PEMPTY;
                    else if (ffill_reg == FCW'(drt_pkg::FLT_DEPTH))
                        ostat_next = drt_pkg::S_FFULL;
                    else
                    begin
                        flt_we     = 1'b1;
                        flt_waddr  = ffill_reg[FAW-1:0];
                        flt_wid    = pend_id_rd_reg;
                        flt_watt   = att_inc;
                        flt_wtime  = now_reg;
                        head_next  = head_reg + PAW'(1);
                        pfill_next = pfill_reg - PCW'(1);
                        ffill_next = ffill_reg + FCW'(1);
                        oid_next   = pend_id_rd_reg;
                        oatt_next  = att_inc;
                    end
                end
                default:
                begin
                    ostat_next = drt_pkg::S_OK;
                end
            endcase
            ovalid_next = 1'b1;
            opc_next    = pfill_next;
            ofc_next    = ffill_next;
            olast_next  = 1'b1;
        end

        if (cmd.p1_start)
        begin
            r_next   = '0;
            cnt_next = '0;
        end

        if (cmd.p1_step)
        begin
            cnt_next = cnt_reg + FCW'(elig);
            r_next   = r_reg + FCW'(1);
        end

        // settle the counts the whole step ends with before anything moves
        if (cmd.p2_start)
        begin
            moved_next   = moved_calc;
            blocked_next = is_tmo && (cnt_reg != moved_calc);
            pfinal_next  = is_tmo ? pfill_reg + PCW'(moved_calc) : pfill_reg;
            ffinal_next  = ffill_reg - moved_calc;
            r_next       = '0;
            w_next       = '0;
            taken_next   = '0;
        end

        if (cmd.p2_step)
        begin
            r_next = r_reg + FCW'(1);
            if (take)
            begin
                taken_next = taken_reg + FCW'(1);
                if (is_tmo)
                begin
                    pend_we    = 1'b1;
                    pend_wid   = flt_id_rd_reg;
                    pend_watt  = flt_att_rd_reg;
                    pfill_next = pfill_reg + PCW'(1);
                end
                if (func_reg != drt_pkg::F_ACK)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = drt_pkg::S_OK;
                    oid_next    = flt_id_rd_reg;
                    oatt_next   = flt_att_rd_reg;
                    opc_next    = pfinal_reg;
                    ofc_next    = ffinal_reg;
                    olast_next  = 1'b0;
                end
            end
            else
            begin
                // compact: keep the entry at the write pointer
                flt_we = 1'b1;
                w_next = w_reg + FCW'(1);
            end
        end

        if (cmd.fin)
        begin
            ffill_next  = w_reg;
            ovalid_next = 1'b1;
            oid_next    = 64'd0;
            oatt_next   = 8'd0;
            opc_next    = pfinal_reg;
            ofc_next    = ffinal_reg;
            olast_next  = 1'b1;
            case (func_reg)
                drt_pkg::F_ACK:
                    ostat_next = (cnt_reg != '0) ? drt_pkg::S_OK : drt_pkg::S_NOTFOUND;
                drt_pkg::F_TMO:
                    ostat_next = blocked_reg ? drt_pkg::S_PFULL : drt_pkg::S_SWEEP_END;
                default:
                    ostat_next = drt_pkg::S_SWEEP_END;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= s_tdata[2:0];
            id_reg   <= s_tdata[66:3];
            now_reg  <= s_tdata[98:67];
            cut_reg  <= s_tdata[130:99];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_id_mem[pend_waddr]  <= pend_wid;
            pend_att_mem[pend_waddr] <= pend_watt;
        end
        pend_id_rd_reg  <= pend_id_mem[head_reg];
        pend_att_rd_reg <= pend_att_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (flt_we)
        begin
            flt_id_mem[flt_waddr]   <= flt_wid;
            flt_att_mem[flt_waddr]  <= flt_watt;
            flt_time_mem[flt_waddr] <= flt_wtime;
        end
        flt_id_rd_reg   <= flt_id_mem[r_reg[FAW-1:0]];
        flt_att_rd_reg  <= flt_att_mem[r_reg[FAW-1:0]];
        flt_time_rd_reg <= flt_time_mem[r_reg[FAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        r_reg       <= r_next;
        w_reg       <= w_next;
        cnt_reg     <= cnt_next;
        moved_reg   <= moved_next;
        taken_reg   <= taken_next;
        blocked_reg <= blocked_next;
        pfinal_reg  <= pfinal_next;
        ffinal_reg  <= ffinal_next;
        ostat_reg   <= ostat_next;
        oid_reg     <= oid_next;
        oatt_reg    <= oatt_next;
        opc_reg     <= opc_next;
        ofc_reg     <= ofc_next;
        olast_reg   <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            pfill_reg  <= '0;
            ffill_reg  <= '0;
            ovalid_reg <= 1'b0;
            limit_reg  <= 8'd3;
        end
        else
        begin
            head_reg   <= head_next;
            pfill_reg  <= pfill_next;
            ffill_reg  <= ffill_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid)
                limit_reg <= cfg_data;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {ofc_reg, opc_reg, oatt_reg, oid_reg, ostat_reg};
    assign m_tlast  = olast_reg;

endmodule

[rtl/core/dispatch_retry_tracker.sv]
// Dispatch and retry tracker top level: joins the sequencer and the datapath.
// Depends on drt_pkg, drt_ctrl and drt_datapath.
//
// One item at a time. Push, dispatch and unknown codes take a decode and an
// execute state. Acknowledge, timeout sweep and retry sweep walk the
// in-flight list twice, first to count matching entries so every result
// carries the final fill counts, then to move, report and compact; the
// in-flight memory has a registered read port, so each entry takes a read
// and an evaluate state per pass. The output register lets the next item
// be accepted while the last result of the previous one waits. retry_limit
// is written through cfg_valid/cfg_data, always ready; the user must write
// it only while the block is idle; the block itself does not enforce it.
module dispatch_retry_tracker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[2:0], item_id[66:3], now_time[98:67], cutoff_time[130:99], zero pad
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], out_id[66:3], out_attempts[74:67], pending_count[81:75],
    // in_flight_count[87:82]
    output logic [87:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);

    drt_pkg::dp_cmd_t  cmd;
    drt_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    drt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    drt_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_pfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pfill <= 7'(drt_pkg::PEND_DEPTH))
        else $error("pending fill beyond depth");

    a_ffill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.ffill <= 6'(drt_pkg::FLT_DEPTH))
        else $error("in-flight fill beyond depth");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

[dv/tb_top.sv]
// Testbench for dispatch_retry_tracker: drives random and directed operations
// and checks every result against a behavioral tracker model in a scoreboard.
// Depends on drt_pkg and the dispatch_retry_tracker RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] id;
        logic [7:0]  attempts;
        logic [6:0]  pcount;
        logic [5:0]  fcount;
        logic        last;
    } tracker_result_t;

    class tracker_scoreboard;
        logic [63:0] pend_id[drt_pkg::PEND_DEPTH];
        logic [7:0]  pend_att[drt_pkg::PEND_DEPTH];
        int          pend_head;
        int          pend_fill;
        logic [63:0] flt_id[$];
        logic [7:0]  flt_att[$];
        logic [31:0] flt_time[$];
        logic [7:0]  limit;
        tracker_result_t awaited[$];
        int          errors;

        function void clear();
            pend_head = 0;
            pend_fill = 0;
            flt_id = {};
            flt_att = {};
            flt_time = {};
            limit = 8'd3;
            awaited = {};
            errors = 0;
        endfunction

        function bit pend_push(logic [63:0] id, logic [7:0] att);
            int slot;
            if (pend_fill >= drt_pkg::PEND_DEPTH)
                return 0;
            slot = (pend_head + pend_fill) % drt_pkg::PEND_DEPTH;
            pend_id[slot] = id;
            pend_att[slot] = att;
            pend_fill++;
            return 1;
        endfunction

        function void note_item(logic [2:0] func, logic [63:0] id, logic [31:0] now,
                                logic [31:0] cutoff);
            tracker_result_t step[$];
            tracker_result_t r;
            logic [63:0] nid[$];
            logic [7:0]  natt[$];
            logic [31:0] ntime[$];
            bit hit;
            bit blocked;
            bit take;
            logic [7:0] att;
            r = '0;
            hit = 0;
            blocked = 0;
            if (func == drt_pkg::F_PUSH)
            begin
                r.status = pend_push(id, 8'd0) ? drt_pkg::S_OK : drt_pkg::S_PFULL;
                step = {step, r};
            end
            else if (func == drt_pkg::F_DISP)
            begin
                if (pend_fill == 0)
                    r.status = drt_pkg::S_PEMPTY;
                else if (flt_id.size() >= drt_pkg::FLT_DEPTH)
                    r.status = drt_pkg::S_FFULL;
                else
                begin
                    att = pend_att[pend_head];
                    if (att != 8'hFF)
                        att++;
                    r.status = drt_pkg::S_OK;
                    r.id = pend_id[pend_head];
                    r.attempts = att;
                    pend_head = (pend_head + 1) % drt_pkg::PEND_DEPTH;
                    pend_fill--;
                    flt_id = {flt_id, r.id};
                    flt_att = {flt_att, att};
                    flt_time = {flt_time, now};
                end
                step = {step, r};
            end
            else if (func == drt_pkg::F_ACK || func == drt_pkg::F_TMO
                     || func == drt_pkg::F_RETRY)
            begin
                foreach (flt_id[i])
                begin
                    take = 0;
                    r = '0;
                    if (func == drt_pkg::F_ACK)
                    begin
                        take = (flt_id[i] == id);
                        hit |= take;
                    end
                    else if (func == drt_pkg::F_TMO)
                    begin
                        if (flt_time[i] < cutoff)
                        begin
                            if (pend_push(flt_id[i], flt_att[i]))
                                take = 1;
                            else
                                blocked = 1;
                        end
                    end
                    else
                        take = (flt_att[i] >= limit);
                    if (take && func != drt_pkg::F_ACK)
                    begin
                        r.id = flt_id[i];
                        r.attempts = flt_att[i];
                        step = {step, r};
                    end
                    if (!take)
                    begin
                        nid = {nid, flt_id[i]};
                        natt = {natt, flt_att[i]};
                        ntime = {ntime, flt_time[i]};
                    end
                end
                flt_id = nid;
                flt_att = natt;
                flt_time = ntime;
                r = '0;
                if (func == drt_pkg::F_ACK)
                    r.status = hit ? drt_pkg::S_OK : drt_pkg::S_NOTFOUND;
                else
                    r.status = blocked ? drt_pkg::S_PFULL : drt_pkg::S_SWEEP_END;
                step = {step, r};
            end
            else
                step = {step, r};
            foreach (step[i])
            begin
                step[i].pcount = pend_fill[6:0];
                step[i].fcount = 6'(flt_id.size());
                step[i].last = (i == step.size() - 1);
                awaited = {awaited, step[i]};
            end
        endfunction

        function void check_result(tracker_result_t got);
            tracker_result_t exp;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = awaited[0];
            awaited.delete(0);
            if (got !== exp)
            begin
                $display("%0t: mismatch expected st=%0d id=%h att=%0d pc=%0d fc=%0d l=%b",
                         $time, exp.status, exp.id, exp.attempts, exp.pcount,
                         exp.fcount, exp.last);
                $display("%0t:          actual   st=%0d id=%h att=%0d pc=%0d fc=%0d l=%b",
                         $time, got.status, got.id, got.attempts, got.pcount,
                         got.fcount, got.last);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;

    tracker_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    logic [63:0] recent_ids[$];

    dispatch_retry_tracker uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Receiver: random stall, check on each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_result({m_tdata[2:0], m_tdata[66:3], m_tdata[74:67],
                                    m_tdata[81:75], m_tdata[87:82], m_tlast});
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid stays high after an accept until the next idle gap or a drain.
    task automatic send_item(logic [2:0] func, logic [63:0] id, logic [31:0] now,
                             logic [31:0] cutoff);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, cutoff, now, id, func};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_item(func, id, now, cutoff);
        if (func == drt_pkg::F_PUSH)
            recent_ids = {recent_ids, id};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_limit(logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.limit = value;
    endtask

    function automatic logic [63:0] rand_id();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (recent_ids.size() != 0 && $urandom_range(2) != 0)
            v = recent_ids[$urandom_range(recent_ids.size() - 1)];
        return v;
    endfunction

    task automatic random_phase(int count);
        int pick;
        logic [31:0] t;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            t = $urandom_range(1000);
            if (pick < 35)
                send_item(drt_pkg::F_PUSH, {$urandom, $urandom}, $urandom, $urandom);
            else if (pick < 65)
                send_item(drt_pkg::F_DISP, {$urandom, $urandom}, t, $urandom);
            else if (pick < 78)
                send_item(drt_pkg::F_ACK, rand_id(), $urandom, $urandom);
            else if (pick < 87)
                send_item(drt_pkg::F_TMO, {$urandom, $urandom}, $urandom,
                          $urandom_range(1000));
            else if (pick < 96)
                send_item(drt_pkg::F_RETRY, {$urandom, $urandom}, $urandom, $urandom);
            else
                send_item(3'($urandom_range(7, 5)), {$urandom, $urandom}, $urandom,
                          $urandom);
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dispatch, misses, extremes, unknown codes.
        send_item(drt_pkg::F_DISP, '0, '0, '0);
        send_item(drt_pkg::F_ACK, '1, '0, '0);
        send_item(drt_pkg::F_TMO, '0, '0, '1);
        send_item(drt_pkg::F_RETRY, '0, '0, '0);
        send_item(3'd7, '1, '1, '1);
        send_item(3'd5, '0, '0, '0);
        send_item(3'd6, '0, '0, '0);
        send_item(drt_pkg::F_PUSH, '1, '1, '1);
        send_item(drt_pkg::F_PUSH, 64'h0, '0, '0);
        send_item(drt_pkg::F_DISP, '0, 32'hFFFF_FFFF, '0);
        send_item(drt_pkg::F_DISP, '0, 32'h0, '0);
        send_item(drt_pkg::F_ACK, '1, '0, '0);
        send_item(drt_pkg::F_TMO, '0, '0, 32'hFFFF_FFFF);
        send_item(drt_pkg::F_DISP, '0, 32'd5, '0);
        send_item(drt_pkg::F_RETRY, '0, '0, '0);
        write_limit(8'd0);
        send_item(drt_pkg::F_RETRY, '0, '0, '0);
        // Fill pending to overflow, in-flight to overflow.
        for (int i = 0; i < 65; i++)
            send_item(drt_pkg::F_PUSH, {$urandom, $urandom}, '0, '0);
        for (int i = 0; i < 33; i++)
            send_item(drt_pkg::F_DISP, '0, i, '0);
        // Pending nearly full: timeout blocks part way.
        for (int i = 0; i < 30; i++)
            send_item(drt_pkg::F_PUSH, {$urandom, $urandom}, '0, '0);
        send_item(drt_pkg::F_TMO, '0, '0, 32'd20);
        write_limit(8'd255);
        send_item(drt_pkg::F_RETRY, '0, '0, '0);
        write_limit(8'd1);
        send_item(drt_pkg::F_RETRY, '0, '0, '0);

        write_limit(8'd3);
        send_idle_pct = 31;
        recv_idle_pct = 68;
        random_phase(20);
        write_limit(8'($urandom_range(1, 4)));
        send_idle_pct = 68;
        recv_idle_pct = 31;
        random_phase(20);
        write_limit(8'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(20);
        drain();
        if (board.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
